@@ rtl/iss_pkg.sv @@
// Shared constants and types for the indexed stack store.
`default_nettype none

package iss_pkg;

    // Store geometry
    localparam int DEPTH  = 1024;
    localparam int WIDTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the stream words
    localparam int CMD_W    = 3;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int NSIZE_W  = 11;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    // Width used for index and size compares
    localparam int CMP_W = (CNT_W > NSIZE_W) ? CNT_W : NSIZE_W;

    // Bit positions inside the output word
    localparam int OUT_STATUS_LSB = DATA_W;
    localparam int OUT_COUNT_LSB  = DATA_W + STATUS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH     = 3'd0,
        CMD_POP      = 3'd1,
        CMD_PEEK     = 3'd2,
        CMD_READ     = 3'd3,
        CMD_READ_REV = 3'd4,
        CMD_WRITE    = 3'd5,
        CMD_SET_SIZE = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage : iss_pkg

`default_nettype wire

@@ rtl/iss_ram.sv @@
// Single-port synchronous RAM with registered read data.
`default_nettype none

module iss_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 32,
    parameter int ADDR_P  = 10
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic               we,
    input  wire logic [ADDR_P-1:0]  addr,
    input  wire logic [WIDTH_P-1:0] wdata,
    output logic      [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    // Write, or read with the data held until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule : iss_ram

`default_nettype wire

@@ rtl/indexed_stack_store.sv @@
// Top level of the indexed stack store: command decode, count, RAM and result register.
//
// A stack of DEPTH words that also allows indexed access.
// Input channel s_axis: one command word per beat (push, pop, peek, read from
// the bottom, read from the top, write at an index, set the used count).
// Output channel m_axis: exactly one result word per command, in order,
// carrying the read data, a status and the used count after the command.
// Failing commands (empty, out of range, full) flag status and change nothing.
// Timing: the RAM is read at the edge that takes the command, and the result
// register loads from stage 1 once it is free, so a stalled m_axis can delay the result.
// Throughput: one command per cycle while m_axis does not stall. Each command
// makes at most one access to the single RAM port, and a write lands in the
// RAM at the edge that takes it, so a read issued right after a write to the
// same entry already sees it.
// When m_axis stalls, one command waits behind the result register and
// s_axis_tready drops after that; nothing is lost or repeated.
// Reset clears the count and the pipeline; the RAM contents are undefined
// until written, so entries uncovered by set size read as undefined.
`default_nettype none

module indexed_stack_store
    import iss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // cmd[2:0], index[12:3], value[44:13], new_size[55:45]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // data[31:0], status[33:32], count[44:34], zero fill[47:45]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Input word fields
    logic [CMD_W-1:0]   in_cmd;
    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;
    logic [NSIZE_W-1:0] in_new_size;

    assign in_cmd      = s_axis_tdata[CMD_W-1:0];
    assign in_index    = s_axis_tdata[CMD_W +: INDEX_W];
    assign in_value    = s_axis_tdata[CMD_W + INDEX_W +: VALUE_W];
    assign in_new_size = s_axis_tdata[CMD_W + INDEX_W + VALUE_W +: NSIZE_W];

    // State
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               p1_valid_reg;
    logic               p1_rd_reg;
    status_t            p1_status_reg;
    logic [COUNT_W-1:0] p1_count_reg;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // Decode results
    logic               accept;
    logic               p1_adv;
    logic               dec_rd;
    logic               dec_wr;
    status_t            dec_status;
    logic [CMP_W-1:0]   dec_addr;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   nsz_ext;

    // RAM port
    logic               ram_en;
    logic [ADDR_W-1:0]  ram_addr;
    logic [WIDTH-1:0]   ram_wdata;
    logic [WIDTH-1:0]   ram_rdata;

    // Handshake
    assign p1_adv        = p1_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~p1_valid_reg | p1_adv;
    assign accept        = s_axis_tvalid & s_axis_tready;

    assign cnt_ext = CMP_W'(count_reg);
    assign idx_ext = CMP_W'(in_index);
    assign nsz_ext = CMP_W'(in_new_size);

    // Command decode: status, RAM access and next count
    always_comb
    begin
        dec_rd     = 1'b0;
        dec_wr     = 1'b0;
        dec_status = ST_OK;
        dec_addr   = '0;
        count_next = count_reg;
        case (cmd_t'(in_cmd))
            CMD_PUSH:
            begin
                if (cnt_ext >= CMP_W'(DEPTH))
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_wr     = 1'b1;
                    dec_addr   = cnt_ext;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_rd     = 1'b1;
                    dec_addr   = cnt_ext - CMP_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_PEEK:
            begin
                if (count_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_rd   = 1'b1;
                    dec_addr = cnt_ext - CMP_W'(1);
                end
            end
            CMD_READ:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_rd   = 1'b1;
                    dec_addr = idx_ext;
                end
            end
            CMD_READ_REV:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_rd   = 1'b1;
                    dec_addr = cnt_ext - idx_ext - CMP_W'(1);
                end
            end
            CMD_WRITE:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_wr   = 1'b1;
                    dec_addr = idx_ext;
                end
            end
            CMD_SET_SIZE:
            begin
                if (nsz_ext > CMP_W'(DEPTH))
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    count_next = CNT_W'(nsz_ext);
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    assign ram_en    = accept & (dec_rd | dec_wr);
    assign ram_addr  = dec_addr[ADDR_W-1:0];
    assign ram_wdata = WIDTH'(in_value);

    iss_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (WIDTH),
        .ADDR_P  (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (dec_wr),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Output valid: loads from stage 1, clears when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (p1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_rd_reg     <= dec_rd;
            p1_status_reg <= dec_status;
            p1_count_reg  <= COUNT_W'(count_next);
        end
        if (p1_adv)
        begin
            out_data_reg   <= p1_rd_reg ? DATA_W'(ram_rdata) : '0;
            out_status_reg <= p1_status_reg;
            out_count_reg  <= p1_count_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_count_reg, out_status_reg, out_data_reg});

endmodule : indexed_stack_store

`default_nettype wire

@@ rtl/iss_checker.sv @@
// Port-level checks for the indexed stack store, bound to the top level.
`default_nettype none

module iss_checker
    import iss_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [DATA_W-1:0]   o_data;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_count;

    assign o_data   = m_axis_tdata[DATA_W-1:0];
    assign o_status = m_axis_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign o_count  = m_axis_tdata[OUT_COUNT_LSB +: COUNT_W];

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Failed commands return zero data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && o_status != ST_OK |-> o_data == '0)
        else $error("error result carries data");

    // Empty status only with an empty store
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && o_status == ST_EMPTY |-> o_count == '0)
        else $error("empty status with nonzero count");

    // A command taken while no result word is shown brings a result word out through stage 1
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result not shown after two cycles");

endmodule : iss_checker

bind indexed_stack_store iss_checker u_iss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the indexed stack store: directed and random stream traffic.
`timescale 1ns / 100ps

module tb_top;
    import iss_pkg::*;

    // Unused command code: the block answers ok and changes nothing
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_WORDS = 1925;

    // Fields of one result word
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } result_t;

    // Keeps its own copy of the store and count; queues the result of each
    // accepted command and matches the block's results against it in order.
    class stack_scoreboard;
        logic [WIDTH-1:0] words [DEPTH];
        bit               written [DEPTH];
        int unsigned      used;
        result_t          expected_results [$];
        int unsigned      errors;

        function new();
            used   = 0;
            errors = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] op, logic [INDEX_W-1:0] idx,
                                   logic [VALUE_W-1:0] val, logic [NSIZE_W-1:0] nsz);
            result_t r;
            r.data   = '0;
            r.status = ST_OK;
            case (op)
                CMD_PUSH:
                    if (used >= DEPTH) r.status = ST_FULL;
                    else
                    begin
                        words[used]   = val[WIDTH-1:0];
                        written[used] = 1'b1;
                        used++;
                    end
                CMD_POP:
                    if (used == 0) r.status = ST_EMPTY;
                    else
                    begin
                        used--;
                        r.data = DATA_W'(words[used]);
                    end
                CMD_PEEK:
                    if (used == 0) r.status = ST_EMPTY;
                    else r.data = DATA_W'(words[used-1]);
                CMD_READ:
                    if (idx >= used) r.status = ST_RANGE;
                    else r.data = DATA_W'(words[idx]);
                CMD_READ_REV:
                    if (idx >= used) r.status = ST_RANGE;
                    else r.data = DATA_W'(words[used-idx-1]);
                CMD_WRITE:
                    if (idx >= used) r.status = ST_RANGE;
                    else
                    begin
                        words[idx]   = val[WIDTH-1:0];
                        written[idx] = 1'b1;
                    end
                CMD_SET_SIZE:
                    if (nsz > DEPTH) r.status = ST_FULL;
                    else used = 32'(nsz);
                default: ;
            endcase
            r.count = COUNT_W'(used);
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            result_t            exp;
            logic [DATA_W-1:0]  got_data;
            logic [STATUS_W-1:0] got_status;
            logic [COUNT_W-1:0] got_count;
            got_data   = word[DATA_W-1:0];
            got_status = word[OUT_STATUS_LSB +: STATUS_W];
            got_count  = word[OUT_COUNT_LSB +: COUNT_W];
            if (expected_results.size() == 0)
            begin
                $error("result word %h arrived with nothing expected", word);
                errors++;
                return;
            end
            exp = expected_results.pop_front();
            if (got_data !== exp.data)
            begin
                $error("data: expected %h, got %h", exp.data, got_data);
                errors++;
            end
            if (got_status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got_status);
                errors++;
            end
            if (got_count !== exp.count)
            begin
                $error("count: expected %0d, got %0d", exp.count, got_count);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    stack_scoreboard sb = new();
    bit              quiet = 1'b0;
    int unsigned     cycles = 0;

    indexed_stack_store u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Receiver back-pressure, off during the quiet stretch
    always @(negedge clk)
        m_axis_tready <= quiet || ($urandom_range(99) >= 15);

    // Result monitor
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Random filler for fields a command ignores
    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom());
    endfunction

    function automatic logic [NSIZE_W-1:0] rand_size();
        return NSIZE_W'($urandom());
    endfunction

    // Drive one command word; returns at the falling edge after it is taken
    task automatic send_word(logic [CMD_W-1:0] op, logic [INDEX_W-1:0] idx,
                             logic [VALUE_W-1:0] val, logic [NSIZE_W-1:0] nsz);
        if (!quiet && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nsz, val, idx, op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_command(op, idx, val, nsz);
        @(negedge clk);
    endtask

    // Hold the input back until every pending result is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    // One random command, weighted by phase; reads of never-written entries
    // are turned into writes of that entry
    task automatic send_random(int unsigned phase);
        int unsigned cut [3][7] = '{'{60, 66, 72, 80, 88, 95, 98},
                                    '{30, 45, 52, 64, 76, 88, 96},
                                    '{15, 60, 66, 75, 84, 92, 98}};
        int unsigned r;
        int unsigned e;
        logic [CMD_W-1:0]   op;
        logic [INDEX_W-1:0] idx;
        logic [NSIZE_W-1:0] nsz;
        r  = $urandom_range(99);
        op = CMD_UNUSED;
        for (int k = 6; k >= 0; k--)
            if (r < cut[phase][k]) op = CMD_W'(k);
        if (sb.used > 0 && $urandom_range(1))
            idx = INDEX_W'($urandom_range(sb.used - 1));
        else
            idx = INDEX_W'($urandom_range(1023));
        case ($urandom_range(3))
            0: nsz = NSIZE_W'($urandom_range(4));
            1: nsz = NSIZE_W'(DEPTH - $urandom_range(4));
            2: nsz = NSIZE_W'($urandom_range(DEPTH));
            default: nsz = NSIZE_W'($urandom_range(2047));
        endcase
        // keep clear of entries that were never written
        case (op)
            CMD_POP, CMD_PEEK:
                if (sb.used > 0 && !sb.written[sb.used-1])
                begin
                    op  = CMD_WRITE;
                    idx = INDEX_W'(sb.used - 1);
                end
            CMD_READ:
                if (idx < sb.used && !sb.written[idx]) op = CMD_WRITE;
            CMD_READ_REV:
                if (idx < sb.used)
                begin
                    e = sb.used - idx - 1;
                    if (!sb.written[e])
                    begin
                        op  = CMD_WRITE;
                        idx = INDEX_W'(e);
                    end
                end
            default: ;
        endcase
        send_word(op, idx, $urandom(), nsz);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty store, bad indexes, unused code, extremes, full store
        send_word(CMD_POP,      rand_index(), $urandom(), rand_size());
        send_word(CMD_PEEK,     rand_index(), $urandom(), rand_size());
        send_word(CMD_READ,     '0, $urandom(), rand_size());
        send_word(CMD_READ_REV, '0, $urandom(), rand_size());
        send_word(CMD_WRITE,    '0, $urandom(), rand_size());
        send_word(CMD_UNUSED,   rand_index(), $urandom(), rand_size());
        send_word(CMD_SET_SIZE, rand_index(), $urandom(), 11'd2047);
        send_word(CMD_PUSH,     rand_index(), 32'h0000_0000, rand_size());
        send_word(CMD_PUSH,     rand_index(), 32'hFFFF_FFFF, rand_size());
        send_word(CMD_PEEK,     rand_index(), $urandom(), rand_size());
        send_word(CMD_READ,     10'd0, $urandom(), rand_size());
        send_word(CMD_READ_REV, 10'd0, $urandom(), rand_size());
        send_word(CMD_READ_REV, 10'd1, $urandom(), rand_size());
        send_word(CMD_WRITE,    10'd1, 32'hA5A5_5A5A, rand_size());
        send_word(CMD_READ,     10'd1, $urandom(), rand_size());
        send_word(CMD_POP,      rand_index(), $urandom(), rand_size());
        send_word(CMD_SET_SIZE, rand_index(), $urandom(), NSIZE_W'(DEPTH));
        send_word(CMD_PUSH,     rand_index(), $urandom(), rand_size());
        send_word(CMD_WRITE,    10'd1023, 32'h8000_0001, rand_size());
        send_word(CMD_READ,     10'd1023, $urandom(), rand_size());
        send_word(CMD_READ_REV, 10'd0, $urandom(), rand_size());
        send_word(CMD_POP,      rand_index(), $urandom(), rand_size());
        send_word(CMD_SET_SIZE, rand_index(), $urandom(), NSIZE_W'(DEPTH + 1));
        send_word(CMD_SET_SIZE, rand_index(), $urandom(), 11'd0);
        send_word(CMD_READ_REV, 10'd1023, $urandom(), rand_size());
        drain_results();

        // Random: fill, mixed and drain phases in turn
        for (int unsigned i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 700) quiet = 1'b1;
            if (i == 1000) quiet = 1'b0;
            if (i == 1200) drain_results();
            send_random((i / 250) % 3);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
